// ===== rtl/core/hbc_pkg.sv =====
package hbc_pkg;

  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 3;
  localparam int BSIZE_W        = 3;
  localparam int KEY_COLS       = 4;
  localparam int KEY_ROW_IDX_W  = 2;
  localparam int KEY_W          = KEY_COLS * BYTE_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int PROD_W         = 2 * BYTE_W;
  localparam int ACC_W          = PROD_W + KEY_ROW_IDX_W;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 3'd0,
    REG_KEY_ROW0   = 3'd1,
    REG_KEY_ROW1   = 3'd2,
    REG_KEY_ROW2   = 3'd3,
    REG_KEY_ROW3   = 3'd4
  } cfg_reg_t;

  typedef logic [KEY_COLS-1:0][BYTE_W-1:0] blk_vec_t;
  typedef logic [KEY_COLS-1:0][KEY_W-1:0]  key_mat_t;

  typedef struct packed {
    blk_vec_t          blk;
    logic [CNT_W-1:0]  last_idx;
    logic              msg_end;
  } blk_entry_t;

endpackage

// ===== rtl/core/hbc_front.sv =====
module hbc_front #(
  parameter int MAX_BLOCK = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hbc_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_message_end,
  input  logic [hbc_pkg::BSIZE_W-1:0]  block_size,
  input  logic                         q_full,
  output logic                         push,
  output hbc_pkg::blk_entry_t          entry
);
  import hbc_pkg::*;

  localparam int BUF_D = (MAX_BLOCK < KEY_COLS) ? MAX_BLOCK : KEY_COLS;
  localparam logic [CNT_W:0] MAX_N = (CNT_W+1)'(MAX_BLOCK);

  logic [BYTE_W-1:0] buf_r [BUF_D];
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W:0]    n_eff;
  logic              in_fire;
  logic              complete;
  blk_vec_t          blk_w;

  always_comb begin
    if (block_size == '0) begin
      n_eff = (CNT_W+1)'(1);
    end else if ({1'b0, block_size} > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = {1'b0, block_size};
    end
  end

  assign in_ready = !q_full;
  assign in_fire  = in_valid && !q_full;
  assign fill_inc = CNT_W'(fill_r + 1'b1);
  assign complete = in_fire && (({1'b0, fill_inc} >= n_eff) || in_message_end);
  assign fill_nxt = complete ? '0 : fill_inc;

  for (genvar c = 0; c < KEY_COLS; c++) begin : g_lane
    logic keep;
    assign keep = ((CNT_W+1)'(c) < {1'b0, fill_inc}) && ((CNT_W+1)'(c) < n_eff);
    if (c < BUF_D) begin : g_buf
      always_ff @(posedge clk) begin
        if (in_fire && fill_r == CNT_W'(c)) begin
          buf_r[c] <= in_data_byte;
        end
      end
      assign blk_w[c] = !keep ? '0 : (fill_r == CNT_W'(c)) ? in_data_byte : buf_r[c];
    end else begin : g_zero
      assign blk_w[c] = '0;
    end
  end

  assign push           = complete;
  assign entry.blk      = blk_w;
  assign entry.last_idx = CNT_W'(n_eff - 1'b1);
  assign entry.msg_end  = in_message_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_fire) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== rtl/core/hbc_queue.sv =====
module hbc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hbc_pkg::blk_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output hbc_pkg::blk_entry_t  head_entry
);
  import hbc_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_QW = 2;

  blk_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;
  logic [CNT_QW-1:0]  count_nxt;

  assign full       = (count_r == CNT_QW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = CNT_QW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_QW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/core/hbc_back.sv =====
module hbc_back #(
  parameter int MODULUS_VALUE = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  hbc_pkg::blk_entry_t         q_entry,
  output logic                        pop,
  input  hbc_pkg::key_mat_t           key_rows,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hbc_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_run_last,
  output logic                        out_message_end
);
  import hbc_pkg::*;

  localparam int MOD_W = $clog2(MODULUS_VALUE + 1);
  localparam int REM_W = MOD_W + 1;
  localparam logic [ACC_W-1:0] RECIP = ACC_W'((1 << ACC_W) / MODULUS_VALUE);
  localparam logic [ACC_W-1:0] MOD_C = ACC_W'(MODULUS_VALUE);
  localparam logic [REM_W-1:0] MOD_R = REM_W'(MODULUS_VALUE);

  logic                    en;
  logic                    issue;
  logic [CNT_W-1:0]        row_r;
  blk_vec_t                key_row;

  logic                    s1_v_r, s1_last_r, s1_end_r;
  logic [PROD_W-1:0]       prod_r [KEY_COLS];
  logic [PROD_W-1:0]       prod_nxt [KEY_COLS];

  logic                    s2_v_r, s2_last_r, s2_end_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        acc_nxt;

  logic                    s3_v_r, s3_last_r, s3_end_r;
  logic [ACC_W-1:0]        s3_acc_r;
  logic [ACC_W-1:0]        quot_r;
  logic [2*ACC_W-1:0]      qprod;

  logic                    s4_v_r, s4_last_r, s4_end_r;
  logic [REM_W-1:0]        rem_r;
  logic [REM_W-1:0]        rem_nxt;

  logic                    out_valid_r, out_last_r, out_end_r;
  logic [BYTE_W-1:0]       out_byte_r;
  logic [REM_W-1:0]        fixed_rem;

  assign en    = !out_valid_r || out_ready;
  assign issue = q_valid && en;
  assign pop   = issue && (row_r == q_entry.last_idx);

  assign key_row = (row_r < CNT_W'(KEY_COLS)) ?
                   blk_vec_t'(key_rows[row_r[KEY_ROW_IDX_W-1:0]]) : '0;

  always_comb begin
    acc_nxt = '0;
    for (int k = 0; k < KEY_COLS; k++) begin
      prod_nxt[k] = PROD_W'(key_row[k]) * PROD_W'(q_entry.blk[k]);
      acc_nxt     = ACC_W'(acc_nxt + ACC_W'(prod_r[k]));
    end
  end

  assign qprod     = (2*ACC_W)'(acc_r) * (2*ACC_W)'(RECIP);
  assign rem_nxt   = REM_W'(s3_acc_r - ACC_W'(quot_r * MOD_C));
  assign fixed_rem = (rem_r >= MOD_R) ? REM_W'(rem_r - MOD_R) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      if (issue) begin
        row_r <= pop ? '0 : CNT_W'(row_r + 1'b1);
      end
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= prod_nxt;
      s1_last_r  <= (row_r == q_entry.last_idx);
      s1_end_r   <= q_entry.msg_end && (row_r == q_entry.last_idx);
      acc_r      <= acc_nxt;
      s2_last_r  <= s1_last_r;
      s2_end_r   <= s1_end_r;
      s3_acc_r   <= acc_r;
      quot_r     <= qprod[2*ACC_W-1:ACC_W];
      s3_last_r  <= s2_last_r;
      s3_end_r   <= s2_end_r;
      rem_r      <= rem_nxt;
      s4_last_r  <= s3_last_r;
      s4_end_r   <= s3_end_r;
      out_byte_r <= BYTE_W'(fixed_rem);
      out_last_r <= s4_last_r;
      out_end_r  <= s4_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_last_r;
  assign out_message_end = out_end_r;

`ifndef SYNTH
  a_row_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (row_r <= q_entry.last_idx))
    else $error("row counter past end of block");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (rem_r < REM_W'(2 * MODULUS_VALUE)))
    else $error("reduction estimate off by more than one");
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_last_r)
    else $error("message end flagged on a byte that does not close a block");
`endif

endmodule

// ===== rtl/core/hill_block_cipher.sv =====
// Path: a byte that closes a block is written to the block queue; its rows then pass the
// product, sum, quotient, remainder and output registers, one per cycle unless stalled.
// Throughput: one byte in and one out per cycle, set by the one-row-per-cycle dot-product
// pipeline, unless stalled; a two-entry block queue decouples collection from computation.
// Reset (synchronous, active low): fill count, queue and pipeline valid flags cleared,
// block size 4, key rows 0.
module hill_block_cipher #(
  parameter int MAX_BLOCK     = 4,
  parameter int MODULUS_VALUE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hbc_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_message_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hbc_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_run_last,
  output logic                            out_message_end,
  input  logic                            cfg_wr_en,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import hbc_pkg::*;

  logic [BSIZE_W-1:0] block_size_r;
  key_mat_t           key_rows_r;

  logic               q_full;
  logic               q_push;
  blk_entry_t         q_in;
  logic               q_pop;
  logic               q_valid;
  blk_entry_t         q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BSIZE_RESET;
      key_rows_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BLOCK_SIZE: block_size_r  <= cfg_wr_data[BSIZE_W-1:0];
        REG_KEY_ROW0:   key_rows_r[0] <= cfg_wr_data[KEY_W-1:0];
        REG_KEY_ROW1:   key_rows_r[1] <= cfg_wr_data[KEY_W-1:0];
        REG_KEY_ROW2:   key_rows_r[2] <= cfg_wr_data[KEY_W-1:0];
        REG_KEY_ROW3:   key_rows_r[3] <= cfg_wr_data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hbc_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_message_end (in_message_end),
    .block_size     (block_size_r),
    .q_full         (q_full),
    .push           (q_push),
    .entry          (q_in)
  );

  hbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  hbc_back #(
    .MODULUS_VALUE(MODULUS_VALUE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_head),
    .pop             (q_pop),
    .key_rows        (key_rows_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

endmodule
